FILE: rtl/dqpb_pkg.sv
package dqpb_pkg;

	localparam int CNT_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [7:0] DOT_CHAR = 8'h2E;

	localparam logic [5:0] HDR_LAST = 6'd11;
	localparam logic [5:0] TRM_LAST = 6'd4;

	localparam logic [CFG_IDX_W-1:0] REG_TRANSACTION_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_FLAGS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_TYPE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_CLASS    = 2'd3;

	localparam logic [15:0] RST_TRANSACTION_ID = 16'h8008;
	localparam logic [15:0] RST_HEADER_FLAGS   = 16'h0180;
	localparam logic [15:0] RST_QUERY_TYPE     = 16'h0001;
	localparam logic [15:0] RST_QUERY_CLASS    = 16'h0001;

	// one classified character, handed from front to back
	typedef struct packed {
		logic [7:0]       ch;
		logic [CNT_W-1:0] idx;
		logic             store;
		logic             hdr;
		logic             flush;
		logic             fin;
		logic             ovf;
		logic [CNT_W-1:0] fcnt;
	} cmd_t;

endpackage

FILE: rtl/dqpb_front.sv
module dqpb_front
	import dqpb_pkg::*;
#(
	parameter int MAX_LABEL = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] name_char,
	input  logic       name_end,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	logic [CNT_W-1:0] count_q;
	logic             header_sent_q;
	logic             overflow_seen_q;

	logic [CNT_W-1:0] count_d;
	logic             overflow_d;
	logic             room;
	logic [CNT_W-1:0] count_after;
	logic             ovf_after;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		room        = count_q < CNT_W'(MAX_LABEL);
		count_after = room ? count_q + CNT_W'(1) : count_q;
		ovf_after   = overflow_seen_q || !room;

		q_cmd.ch    = name_char;
		q_cmd.idx   = count_q;
		q_cmd.hdr   = !header_sent_q;
		q_cmd.fin   = name_end;
		q_cmd.store = 1'b0;
		q_cmd.flush = 1'b0;
		q_cmd.ovf   = 1'b0;
		q_cmd.fcnt  = count_q;
		count_d     = count_q;
		overflow_d  = overflow_seen_q;

		if (name_char == DOT_CHAR) begin
			// trailing dot with nothing buffered adds no empty label
			q_cmd.flush = !name_end || (count_q != '0);
			q_cmd.ovf   = overflow_seen_q;
			if (q_cmd.flush) begin
				count_d = '0;
			end
			overflow_d = 1'b0;
		end else begin
			q_cmd.store = room;
			count_d     = count_after;
			overflow_d  = ovf_after;
			if (name_end) begin
				q_cmd.flush = 1'b1;
				q_cmd.ovf   = ovf_after;
				q_cmd.fcnt  = count_after;
			end
		end

		if (name_end) begin
			count_d    = '0;
			overflow_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q         <= '0;
			header_sent_q   <= 1'b0;
			overflow_seen_q <= 1'b0;
		end else if (q_push) begin
			count_q         <= count_d;
			header_sent_q   <= !name_end;
			overflow_seen_q <= overflow_d;
		end
	end

endmodule

FILE: rtl/dqpb_queue.sv
module dqpb_queue
	import dqpb_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;

	assign full    = fill_q == CW'(DEPTH);
	assign empty   = fill_q == '0;
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/dqpb_back.sv
module dqpb_back
	import dqpb_pkg::*;
#(
	parameter int MAX_LABEL = 63
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  q_empty,
	input  cmd_t                  q_cmd,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            byte_first,
	output logic [7:0]            byte_second,
	output logic                  pair_full,
	output logic                  run_last,
	output logic                  packet_last,
	output logic                  label_overflow
);

	localparam int IW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_LEN,
		ST_LBL,
		ST_TRM
	} state_t;

	state_t           state_q;
	cmd_t             cur_q;
	logic [CNT_W-1:0] pos_q;
	logic [7:0]       hold_q;
	logic             have_q;
	logic             out_valid_q;
	logic [7:0]       byte_first_q;
	logic [7:0]       byte_second_q;
	logic             pair_full_q;
	logic             run_last_q;
	logic             packet_last_q;
	logic             label_overflow_q;

	logic [15:0] tid_q;
	logic [15:0] flags_q;
	logic [15:0] qtype_q;
	logic [15:0] qclass_q;

	logic [7:0] label_mem [MAX_LABEL];
	logic [7:0] rd_data_q;

	logic [7:0]       cur_byte;
	logic             is_last;
	logic             active;
	logic             emit;
	logic             out_free;
	logic             adv;
	logic             rd_en;
	logic [CNT_W-1:0] rd_addr;
	state_t           after_label;

	assign out_valid      = out_valid_q;
	assign byte_first     = byte_first_q;
	assign byte_second    = byte_second_q;
	assign pair_full      = pair_full_q;
	assign run_last       = run_last_q;
	assign packet_last    = packet_last_q;
	assign label_overflow = label_overflow_q;

	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tid_q    <= RST_TRANSACTION_ID;
			flags_q  <= RST_HEADER_FLAGS;
			qtype_q  <= RST_QUERY_TYPE;
			qclass_q <= RST_QUERY_CLASS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRANSACTION_ID: tid_q    <= cfg_wdata;
				REG_HEADER_FLAGS:   flags_q  <= cfg_wdata;
				REG_QUERY_TYPE:     qtype_q  <= cfg_wdata;
				REG_QUERY_CLASS:    qclass_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// label buffer, written when a command is popped, read one byte ahead
	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.store) begin
			label_mem[q_cmd.idx[IW-1:0]] <= q_cmd.ch;
		end
		if (rd_en) begin
			rd_data_q <= label_mem[rd_addr[IW-1:0]];
		end
	end

	always_comb begin
		after_label = cur_q.fin ? ST_TRM : ST_IDLE;
		cur_byte    = 8'h00;
		is_last     = 1'b0;
		unique case (state_q)
			ST_HDR: begin
				case (pos_q)
					6'd0:    cur_byte = tid_q[15:8];
					6'd1:    cur_byte = tid_q[7:0];
					6'd2:    cur_byte = flags_q[15:8];
					6'd3:    cur_byte = flags_q[7:0];
					6'd5:    cur_byte = 8'h01;
					default: cur_byte = 8'h00;
				endcase
				is_last = (pos_q == HDR_LAST) && !cur_q.flush && !cur_q.fin;
			end
			ST_LEN: begin
				cur_byte = 8'(cur_q.fcnt);
				is_last  = (cur_q.fcnt == '0) && !cur_q.fin;
			end
			ST_LBL: begin
				cur_byte = rd_data_q;
				is_last  = (pos_q == cur_q.fcnt - CNT_W'(1)) && !cur_q.fin;
			end
			ST_TRM: begin
				case (pos_q)
					6'd1:    cur_byte = qtype_q[15:8];
					6'd2:    cur_byte = qtype_q[7:0];
					6'd3:    cur_byte = qclass_q[15:8];
					6'd4:    cur_byte = qclass_q[7:0];
					default: cur_byte = 8'h00;
				endcase
				is_last = pos_q == TRM_LAST;
			end
			default: ;
		endcase

		active   = state_q != ST_IDLE;
		emit     = active && (have_q || is_last);
		out_free = !out_valid_q || out_ready;
		adv      = active && (!emit || out_free);

		rd_en   = 1'b0;
		rd_addr = '0;
		if (adv && (state_q == ST_LEN) && (cur_q.fcnt != '0)) begin
			rd_en = 1'b1;
		end
		if (adv && (state_q == ST_LBL) && (pos_q != cur_q.fcnt - CNT_W'(1))) begin
			rd_en   = 1'b1;
			rd_addr = pos_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (adv) begin
				if (emit) begin
					have_q           <= 1'b0;
					pair_full_q      <= have_q;
					byte_first_q     <= have_q ? hold_q : cur_byte;
					byte_second_q    <= have_q ? cur_byte : 8'h00;
					run_last_q       <= is_last;
					packet_last_q    <= is_last && cur_q.fin;
					label_overflow_q <= cur_q.flush && cur_q.ovf;
				end else begin
					have_q <= 1'b1;
					hold_q <= cur_byte;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						cur_q <= q_cmd;
						pos_q <= '0;
						if (q_cmd.hdr) begin
							state_q <= ST_HDR;
						end else if (q_cmd.flush) begin
							state_q <= ST_LEN;
						end else if (q_cmd.fin) begin
							state_q <= ST_TRM;
						end
					end
				end
				ST_HDR: begin
					if (adv) begin
						if (pos_q == HDR_LAST) begin
							pos_q <= '0;
							if (cur_q.flush) begin
								state_q <= ST_LEN;
							end else begin
								state_q <= after_label;
							end
						end else begin
							pos_q <= pos_q + CNT_W'(1);
						end
					end
				end
				ST_LEN: begin
					if (adv) begin
						pos_q   <= '0;
						state_q <= (cur_q.fcnt != '0) ? ST_LBL : after_label;
					end
				end
				ST_LBL: begin
					if (adv) begin
						if (pos_q == cur_q.fcnt - CNT_W'(1)) begin
							pos_q   <= '0;
							state_q <= after_label;
						end else begin
							pos_q <= pos_q + CNT_W'(1);
						end
					end
				end
				ST_TRM: begin
					if (adv) begin
						if (pos_q == TRM_LAST) begin
							pos_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							pos_q <= pos_q + CNT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pkt_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && packet_last_q |-> run_last_q)
		else $error("packet end not on last beat of its run");

	a_label_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LBL |-> pos_q < cur_q.fcnt)
		else $error("label read past buffered count");

	a_hdr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HDR |-> pos_q <= HDR_LAST)
		else $error("header position out of range");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q != ST_IDLE || $past(!q_cmd.hdr && !q_cmd.flush && !q_cmd.fin))
		else $error("popped command with bytes left idle");
`endif

endmodule

FILE: rtl/dns_query_packet_builder_core.sv
// channel   dir  handshake         payload
// s_*       in   s_tvalid/tready   tdata = name_char, tlast = name_end
// m_*       out  m_tvalid/tready   tdata = byte_first, byte_second; tlast = packet_last;
//                                  tuser = pair_full, run_last, label_overflow
// cfg_*     in   cfg_we            cfg_index selects register, cfg_wdata value
//
// the front takes one character a cycle while the command queue has room
// the back pops a command only while idle, then steps through its packet bytes; a
// buffering character emits no bytes but the header, a flush its length and label
// output beats carry up to two bytes; a stalled m_tready holds the byte sequencer only
// reset clears control state and loads the register defaults; no clearing pass
module dns_query_packet_builder_core
	import dqpb_pkg::*;
#(
	parameter int MAX_LABEL   = 63,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // name_char
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // byte_first, byte_second
	output logic                  m_tlast,
	output logic [2:0]            m_tuser,   // pair_full, run_last, label_overflow
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// classified characters between front and back
	cmd_t push_cmd;
	cmd_t pop_cmd;
	logic push;
	logic pop;
	logic full;
	logic empty;

	// back side result fields
	logic [7:0] byte_first;
	logic [7:0] byte_second;
	logic       pair_full;
	logic       run_last;
	logic       packet_last;
	logic       label_overflow;

	// front: tracks label count, header and overflow state per character
	dqpb_front #(
		.MAX_LABEL (MAX_LABEL)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.name_char (s_tdata),
		.name_end  (s_tlast),
		.q_full    (full),
		.q_push    (push),
		.q_cmd     (push_cmd)
	);

	// short command queue lets front and back stall independently
	dqpb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty)
	);

	// back: label buffer, byte sequencer and pair packer
	dqpb_back #(
		.MAX_LABEL (MAX_LABEL)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.q_empty        (empty),
		.q_cmd          (pop_cmd),
		.q_pop          (pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.byte_first     (byte_first),
		.byte_second    (byte_second),
		.pair_full      (pair_full),
		.run_last       (run_last),
		.packet_last    (packet_last),
		.label_overflow (label_overflow)
	);

	assign m_tdata = {byte_second, byte_first};
	assign m_tlast = packet_last;
	assign m_tuser = {label_overflow, run_last, pair_full};

endmodule
